// ===== rtl/ntc_pkg.sv =====
// Package with shared constants, codes and types of the NTC thermistor block.
`timescale 1ns / 1ps
package ntc_pkg;

    // Defaults of the top-level parameters.
    localparam int AVG_COUNT_DEF = 10;
    localparam int ADC_BITS_DEF  = 12;

    // Port widths fixed by the item fields.
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 16;
    localparam int TEMP_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Output limits in hundredths of a degree Celsius.
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd100000;

    // ln 2 in Q0.30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERIES_OHMS    = 3'd0,
        REG_BETA           = 3'd1,
        REG_REF_TEMP_C     = 3'd2,
        REG_REF_OHMS       = 3'd3,
        REG_ADC_FULL_SCALE = 3'd4
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [19:0]       SERIES_RST = 20'd10000;
    localparam logic [16:0]       BETA_RST   = 17'd3950;
    localparam logic signed [8:0] REFT_RST   = 9'sd25;
    localparam logic [19:0]       REFO_RST   = 20'd10000;
    localparam logic [11:0]       FS_RST     = 12'd1023;

    // Handshake between the batch queue and the conversion engine.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_batch;

    typedef struct packed {
        logic pop;
    } t_batch_ack;

endpackage

// ===== rtl/ntc_if.sv =====
// Valid/ready channel interfaces for samples, results and configuration writes.
`timescale 1ns / 1ps
interface ntc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ntc_pkg::SAMPLE_W-1:0]  sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ntc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ntc_pkg::TEMP_W-1:0]   temp_centi_c;
    logic                                fault;
    modport source (output valid, output temp_centi_c, output fault, input ready);
    modport sink   (input valid, input temp_centi_c, input fault, output ready);
endinterface

interface ntc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ntc_pkg::CFG_IDX_W-1:0]   index;
    logic [ntc_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ntc_front.sv =====
// Sample accumulator: sums samples and hands each finished batch sum to the queue.
`timescale 1ns / 1ps
module ntc_front #(
    parameter int AVG_COUNT = ntc_pkg::AVG_COUNT_DEF,
    parameter int ADC_BITS  = ntc_pkg::ADC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ntc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [ntc_pkg::SUM_W-1:0]    o_sum
);
    localparam logic [ntc_pkg::SAMPLE_W-1:0] MASK =
        (ADC_BITS >= ntc_pkg::SAMPLE_W) ? '1 : ntc_pkg::SAMPLE_W'((1 << ADC_BITS) - 1);
    localparam logic [3:0] LAST = 4'(AVG_COUNT - 1);

    logic [ntc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [3:0]                r_idx;
    logic                      w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign n_sum   = r_sum + ntc_pkg::SUM_W'(i_sample & MASK);
    assign o_push  = w_acc && (r_idx == LAST);
    assign o_sum   = n_sum;

    // Running sum and sample count of the current batch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_idx <= '0;
        end else if (w_acc) begin
            if (r_idx == LAST) begin
                r_sum <= '0;
                r_idx <= '0;
            end else begin
                r_sum <= n_sum;
                r_idx <= r_idx + 4'd1;
            end
        end
    end
endmodule

// ===== rtl/ntc_queue.sv =====
// Two-entry queue of batch sums between the accumulator and the conversion engine.
`timescale 1ns / 1ps
module ntc_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [ntc_pkg::SUM_W-1:0] i_sum,
    output logic                      o_full,
    output ntc_pkg::t_batch           o_batch,
    input  ntc_pkg::t_batch_ack       i_ack
);
    logic [ntc_pkg::SUM_W-1:0] r_mem [2];
    logic                      r_wp, r_rp;
    logic [1:0]                r_cnt;
    logic                      w_pop;

    assign o_full        = (r_cnt == 2'd2);
    assign o_batch.valid = (r_cnt != 2'd0);
    assign o_batch.sum   = r_mem[r_rp];
    assign w_pop         = i_ack.pop && o_batch.valid;

    // Storage for the queued sums.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_sum;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end
endmodule

// ===== rtl/ntc_back.sv =====
// Conversion engine: resistance ratio, log2 by squaring, Beta equation and division.
`timescale 1ns / 1ps
module ntc_back #(
    parameter int AVG_COUNT = ntc_pkg::AVG_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntc_pkg::t_batch     i_batch,
    output ntc_pkg::t_batch_ack o_ack,
    ntc_cfg_if.sink             i_cfg,
    ntc_out_if.source           o_out
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MUL  = 11'b00000000010,
        S_NORM = 11'b00000000100,
        S_SQ   = 11'b00000001000,
        S_LN   = 11'b00000010000,
        S_TOP  = 11'b00000100000,
        S_BOT  = 11'b00001000000,
        S_DSET = 11'b00010000000,
        S_DIV  = 11'b00100000000,
        S_SAT  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    localparam logic [15:0] AVG_N = 16'(AVG_COUNT);

    t_state r_state;

    // Configuration registers.
    logic [19:0]       r_series, r_refo;
    logic [16:0]       r_beta;
    logic signed [8:0] r_reft;
    logic [11:0]       r_fs;

    // Datapath registers.
    logic [15:0]              r_sum;
    logic [35:0]              r_num, r_den;
    logic [5:0]               r_sn, r_sd;
    logic [30:0]              r_m;
    logic [23:0]              r_frac, r_fn;
    logic [4:0]               r_cnt;
    logic                     r_ph;
    logic [59:0]              r_prod;
    logic                     r_neg;
    logic [16:0]              r_tc0;
    logic [22:0]              r_tc100;
    logic [39:0]              r_top;
    logic signed [27:0]       r_lq;
    logic signed [45:0]       r_x;
    logic [23:0]              r_b100;
    logic [60:0]              r_n;
    logic [46:0]              r_r;
    logic [45:0]              r_dv;
    logic [5:0]               r_dcnt;
    logic signed [17:0]       r_res;
    logic                     r_rfault;
    logic                     r_ovalid;
    logic signed [17:0]       r_otemp;
    logic                     r_ofault;

    // Combinational helpers.
    logic [15:0]        w_full;
    logic [61:0]        w_sq;
    logic [31:0]        w_t;
    logic signed [31:0] w_d;
    logic [29:0]        w_mag;
    logic [59:0]        w_rnd;
    logic [25:0]        w_lqm;
    logic signed [17:0] w_tcs;
    logic signed [46:0] w_bot;
    logic [46:0]        w_rr;
    logic               w_ge;
    logic               w_slot;

    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_ovalid;
    assign o_out.temp_centi_c = r_otemp;
    assign o_out.fault        = r_ofault;
    assign o_ack.pop          = (r_state == S_IDLE);

    assign w_full = AVG_N[3:0] * r_fs;
    assign w_sq   = 62'(r_m) * 62'(r_m);
    assign w_t    = w_sq[61:30];
    assign w_d    = ((32'(r_sd) - 32'(r_sn)) <<< 24) + 32'(r_fn) - 32'(r_frac);
    assign w_mag  = w_d[31] ? 30'(-w_d) : 30'(w_d);
    assign w_rnd  = r_prod + (60'd1 << 33);
    assign w_lqm  = w_rnd[59:34];
    assign w_tcs  = 18'(r_reft) * 18'sd100 + 18'sd27315;
    assign w_bot  = $signed({3'b000, r_b100, 20'b0}) + 47'(r_x);
    assign w_rr   = {r_r[45:0], r_n[60]};
    assign w_ge   = (w_rr >= {1'b0, r_dv});
    assign w_slot = !r_ovalid || o_out.ready;

    // Register writes from the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series <= ntc_pkg::SERIES_RST;
            r_beta   <= ntc_pkg::BETA_RST;
            r_reft   <= ntc_pkg::REFT_RST;
            r_refo   <= ntc_pkg::REFO_RST;
            r_fs     <= ntc_pkg::FS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ntc_pkg::REG_SERIES_OHMS:    r_series <= i_cfg.data;
                ntc_pkg::REG_BETA:           r_beta   <= i_cfg.data[16:0];
                ntc_pkg::REG_REF_TEMP_C:     r_reft   <= $signed(i_cfg.data[8:0]);
                ntc_pkg::REG_REF_OHMS:       r_refo   <= i_cfg.data;
                ntc_pkg::REG_ADC_FULL_SCALE: r_fs     <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath of one conversion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_batch.valid) begin
                        r_sum <= i_batch.sum;
                        if (i_batch.sum == 16'd0 || i_batch.sum >= w_full) begin
                            r_res    <= ntc_pkg::TEMP_MIN;
                            r_rfault <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (r_series == '0 || r_refo == '0 || r_beta == '0) begin
                            r_res    <= ntc_pkg::TEMP_MIN;
                            r_rfault <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_rfault <= 1'b0;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_num   <= 36'(r_series) * 36'(r_sum);
                    r_den   <= 36'(w_full - r_sum) * 36'(r_refo);
                    r_tc0   <= w_tcs[16:0];
                    r_sn    <= '0;
                    r_sd    <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // Shift both operands up to the top bit, counting the shifts.
                    if (!r_num[35]) begin
                        r_num <= {r_num[34:0], 1'b0};
                        r_sn  <= r_sn + 6'd1;
                    end
                    if (!r_den[35]) begin
                        r_den <= {r_den[34:0], 1'b0};
                        r_sd  <= r_sd + 6'd1;
                    end
                    if (r_num[35] && r_den[35]) begin
                        r_m     <= r_num[35:5];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // One fraction bit of log2 per squaring; numerator, then denominator.
                    if (r_cnt == 5'd23 && !r_ph) begin
                        r_fn   <= {r_frac[22:0], w_t[31]};
                        r_m    <= r_den[35:5];
                        r_frac <= '0;
                        r_cnt  <= '0;
                        r_ph   <= 1'b1;
                    end else begin
                        r_frac <= {r_frac[22:0], w_t[31]};
                        r_m    <= w_t[31] ? w_t[31:1] : w_t[30:0];
                        r_cnt  <= r_cnt + 5'd1;
                        if (r_cnt == 5'd23) begin
                            r_state <= S_LN;
                        end
                    end
                end
                S_LN: begin
                    r_neg   <= w_d[31];
                    r_prod  <= 60'(w_mag) * 60'(ntc_pkg::LN2_Q30);
                    r_tc100 <= 23'(r_tc0) * 23'd100;
                    r_state <= S_TOP;
                end
                S_TOP: begin
                    r_lq    <= r_neg ? -28'(w_lqm) : 28'(w_lqm);
                    r_top   <= 40'(r_tc100) * 40'(r_beta);
                    r_b100  <= 24'(r_beta) * 24'd100;
                    r_state <= S_BOT;
                end
                S_BOT: begin
                    r_x     <= 46'($signed({1'b0, r_tc0})) * 46'(r_lq);
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    if (w_bot == 47'sd0) begin
                        r_res   <= ntc_pkg::TEMP_MAX;
                        r_state <= S_OUT;
                    end else if (w_bot[46]) begin
                        r_res   <= ntc_pkg::TEMP_MIN;
                        r_state <= S_OUT;
                    end else begin
                        r_dv    <= w_bot[45:0];
                        r_n     <= {1'b0, r_top, 20'b0} + 61'(w_bot[45:1]);
                        r_r     <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_r    <= w_ge ? (w_rr - {1'b0, r_dv}) : w_rr;
                    r_n    <= {r_n[59:0], w_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd60) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_n > 61'd127315) begin
                        r_res <= ntc_pkg::TEMP_MAX;
                    end else begin
                        r_res <= $signed(r_n[17:0] - 18'd27315);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_slot) begin
                        r_otemp  <= r_res;
                        r_ofault <= r_rfault;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/ntc_thermistor_beta_temp.sv =====
// Top level of the NTC thermistor temperature block: accumulator, queue and engine.
// Samples are taken one per cycle while the two-entry batch queue has room.
// Every AVG_COUNT-th sample queues a batch for a conversion of normalize shifts,
// 48 squarings in the shared log2 squarer, 61 divider steps and control states.
// Synchronous active-low reset clears sums, queue, sequencer and output valid.
`timescale 1ns / 1ps
module ntc_thermistor_beta_temp #(
    parameter int AVG_COUNT = ntc_pkg::AVG_COUNT_DEF,
    parameter int ADC_BITS  = ntc_pkg::ADC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntc_in_if.sink    i_in,
    ntc_cfg_if.sink   i_cfg,
    ntc_out_if.source o_out
);
    logic                      w_full, w_push;
    logic [ntc_pkg::SUM_W-1:0] w_sum;
    ntc_pkg::t_batch           w_batch;
    ntc_pkg::t_batch_ack       w_ack;

    ntc_front #(.AVG_COUNT(AVG_COUNT), .ADC_BITS(ADC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_sample (i_in.sample),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_sum    (w_sum)
    );

    ntc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_sum   (w_sum),
        .o_full  (w_full),
        .o_batch (w_batch),
        .i_ack   (w_ack)
    );

    ntc_back #(.AVG_COUNT(AVG_COUNT)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (w_batch),
        .o_ack   (w_ack),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );
endmodule

// ===== rtl/ntc_chk.sv =====
// Port-level checker for the NTC thermistor block and its bind statement.
`timescale 1ns / 1ps
module ntc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [ntc_pkg::TEMP_W-1:0] i_temp,
    input logic                              i_fault
);
    // A pending result stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Reset removes any pending result.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A fault always reports the lowest temperature.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fault |-> i_temp == ntc_pkg::TEMP_MIN)
        else $error("fault with temperature other than minimum");

    // Results are saturated to the output range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_temp >= ntc_pkg::TEMP_MIN) && (i_temp <= ntc_pkg::TEMP_MAX))
        else $error("temperature outside range");
endmodule

bind ntc_thermistor_beta_temp ntc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_temp      (o_out.temp_centi_c),
    .i_fault     (o_out.fault)
);
